// File: design/hls_pkg.sv
// hls_pkg: shared types, constants and helpers of the link keepalive supervisor
// used by every module in design/; the channel interfaces do not depend on it
package hls_pkg;

  localparam int TIME_BITS = 32;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_CHECK_INTERVAL     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HEARTBEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RECEIVE_TIMEOUT    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RETRY_LIMIT        = 2'd3;

  localparam logic [15:0] CHECK_INTERVAL_RST     = 16'd1000;
  localparam logic [15:0] HEARTBEAT_INTERVAL_RST = 16'd2000;
  localparam logic [15:0] RECEIVE_TIMEOUT_RST    = 16'd5000;
  localparam logic [7:0]  RETRY_LIMIT_RST        = 8'd3;

  typedef enum logic [1:0] {
    LINK_CONNECTING = 2'd0,
    LINK_CONNECTED  = 2'd1,
    LINK_ERROR      = 2'd2
  } link_t;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  localparam logic [1:0] KIND_HEARTBEAT = 2'd0;
  localparam logic [1:0] KIND_ACK       = 2'd1;

  localparam logic [7:0] RETRY_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] check_interval;
    logic [15:0] heartbeat_interval;
    logic [15:0] receive_timeout;
    logic [7:0]  retry_limit;
  } cfg_t;

  typedef struct packed {
    logic       action;
    logic [1:0] frame_kind;
    logic       tx_accepted;
  } item_t;

  typedef struct packed {
    link_t      link_status;
    logic       send_heartbeat;
    logic [7:0] heartbeat_payload;
    logic       send_ack;
    logic       became_connected;
  } result_t;

  // retry counter saturates at its maximum
  function automatic logic [7:0] retry_inc(input logic [7:0] cnt);
    logic [7:0] res;
    res = (cnt == RETRY_MAX) ? cnt : cnt + 8'd1;
    return res;
  endfunction

endpackage

// File: design/hls_if.sv
// hls_in_if / hls_out_if: valid/ready channels of the supervisor
// payload widths follow the field list; no package dependency
interface hls_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [1:0] frame_kind;
  logic       tx_accepted;

  modport source(output valid, action, frame_kind, tx_accepted, input ready);
  modport sink(input valid, action, frame_kind, tx_accepted, output ready);
endinterface

interface hls_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_status;
  logic       send_heartbeat;
  logic [7:0] heartbeat_payload;
  logic       send_ack;
  logic       became_connected;

  modport source(output valid, link_status, send_heartbeat, heartbeat_payload,
                 send_ack, became_connected, input ready);
  modport sink(input valid, link_status, send_heartbeat, heartbeat_payload,
               send_ack, became_connected, output ready);
endinterface

// File: design/hls_cfg_regs.sv
// hls_cfg_regs: configuration register file with reset defaults
// depends on hls_pkg
module hls_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [hls_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [hls_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output hls_pkg::cfg_t                    cfg
);

  hls_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_interval     <= hls_pkg::CHECK_INTERVAL_RST;
      cfg_r.heartbeat_interval <= hls_pkg::HEARTBEAT_INTERVAL_RST;
      cfg_r.receive_timeout    <= hls_pkg::RECEIVE_TIMEOUT_RST;
      cfg_r.retry_limit        <= hls_pkg::RETRY_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hls_pkg::CFG_CHECK_INTERVAL:     cfg_r.check_interval     <= cfg_wdata;
        hls_pkg::CFG_HEARTBEAT_INTERVAL: cfg_r.heartbeat_interval <= cfg_wdata;
        hls_pkg::CFG_RECEIVE_TIMEOUT:    cfg_r.receive_timeout    <= cfg_wdata;
        hls_pkg::CFG_RETRY_LIMIT:        cfg_r.retry_limit        <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/hls_in_stage.sv
// hls_in_stage: input register in front of the supervision core
// depends on hls_pkg
module hls_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  hls_pkg::item_t in_item,
  output logic           item_valid,
  input  logic           item_ready,
  output hls_pkg::item_t item
);

  logic           valid_r;
  logic           valid_nxt;
  hls_pkg::item_t item_r;

  // the register frees up in the same cycle the core takes its item
  assign in_ready = !valid_r || item_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (valid_r && item_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: design/hls_core.sv
// hls_core: supervision state, single-pass update per item and result register
// depends on hls_pkg
module hls_core (
  input  logic             clk,
  input  logic             rst_n,
  input  hls_pkg::cfg_t    cfg,
  input  logic             item_valid,
  output logic             item_ready,
  input  hls_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output hls_pkg::result_t res
);

  localparam int TB = hls_pkg::TIME_BITS;

  logic [TB-1:0]    now_ms_r, now_ms_nxt;
  logic [TB-1:0]    last_check_r, last_check_nxt;
  logic [TB-1:0]    last_sent_r, last_sent_nxt;
  logic [TB-1:0]    last_rx_r, last_rx_nxt;
  logic             ack_pending_r, ack_pending_nxt;
  logic [7:0]       retry_r, retry_nxt;
  hls_pkg::link_t   link_r, link_nxt;
  logic             res_valid_r;
  hls_pkg::result_t res_r, res_nxt;

  logic             take;
  logic [TB-1:0]    now_inc;
  logic [TB-1:0]    check_age;
  logic [TB-1:0]    sent_age;
  logic [TB-1:0]    rx_age;
  logic             check_due;
  logic             rx_late;
  logic             ack_late;
  logic             hb_due;
  logic [7:0]       retry_a, retry_b, retry_c;
  hls_pkg::link_t   link_a, link_b, link_c;

  assign item_ready = !res_valid_r || res_ready;
  assign take       = item_valid && item_ready;

  // wrapping ages against the already advanced millisecond count
  assign now_inc   = now_ms_r + TB'(1);
  assign check_age = now_inc - last_check_r;
  assign sent_age  = now_inc - last_sent_r;
  assign rx_age    = now_inc - last_rx_r;
  assign check_due = check_age >= TB'(cfg.check_interval);
  assign rx_late   = rx_age > TB'(cfg.receive_timeout);
  assign ack_late  = ack_pending_r && (sent_age > TB'(cfg.receive_timeout[15:1]));
  assign hb_due    = sent_age >= TB'(cfg.heartbeat_interval);

  // check sequence: receive timeout, ack timeout, heartbeat
  always_comb begin
    retry_a = retry_r;
    link_a  = link_r;
    if (check_due && rx_late &&
        (link_r == hls_pkg::LINK_CONNECTING || link_r == hls_pkg::LINK_CONNECTED)) begin
      retry_a = hls_pkg::retry_inc(retry_r);
      link_a  = (retry_a >= cfg.retry_limit) ? hls_pkg::LINK_ERROR
                                             : hls_pkg::LINK_CONNECTING;
    end
    retry_b = retry_a;
    link_b  = link_a;
    if (check_due && ack_late) begin
      retry_b = hls_pkg::retry_inc(retry_a);
      link_b  = (retry_b >= cfg.retry_limit) ? hls_pkg::LINK_ERROR
                                             : hls_pkg::LINK_CONNECTING;
    end
    retry_c = retry_b;
    link_c  = link_b;
    // a rejected heartbeat counts as a retry but only ever moves to error
    if (check_due && hb_due && !item.tx_accepted) begin
      retry_c = hls_pkg::retry_inc(retry_b);
      if (retry_c >= cfg.retry_limit) begin
        link_c = hls_pkg::LINK_ERROR;
      end
    end
  end

  always_comb begin
    now_ms_nxt      = now_ms_r;
    last_check_nxt  = last_check_r;
    last_sent_nxt   = last_sent_r;
    last_rx_nxt     = last_rx_r;
    ack_pending_nxt = ack_pending_r;
    retry_nxt       = retry_r;
    link_nxt        = link_r;
    res_nxt         = '0;
    if (item.action == hls_pkg::ACT_TICK) begin
      now_ms_nxt = now_inc;
      if (check_due) begin
        last_check_nxt  = now_inc;
        retry_nxt       = retry_c;
        link_nxt        = link_c;
        ack_pending_nxt = ack_late ? 1'b0 : ack_pending_r;
        if (hb_due) begin
          res_nxt.send_heartbeat    = 1'b1;
          res_nxt.heartbeat_payload = retry_b;
          last_sent_nxt             = now_inc;
          if (item.tx_accepted) begin
            ack_pending_nxt = 1'b1;
          end
        end
      end
    end else begin
      last_rx_nxt = now_ms_r;
      if (item.frame_kind == hls_pkg::KIND_HEARTBEAT) begin
        res_nxt.send_ack = 1'b1;
        if (item.tx_accepted && link_r != hls_pkg::LINK_CONNECTED) begin
          link_nxt                 = hls_pkg::LINK_CONNECTED;
          retry_nxt                = 8'd0;
          res_nxt.became_connected = 1'b1;
        end
      end else if (item.frame_kind == hls_pkg::KIND_ACK) begin
        ack_pending_nxt = 1'b0;
        if (link_r != hls_pkg::LINK_CONNECTED) begin
          link_nxt                 = hls_pkg::LINK_CONNECTED;
          retry_nxt                = 8'd0;
          res_nxt.became_connected = 1'b1;
        end
      end
    end
    res_nxt.link_status = link_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_ms_r      <= '0;
      last_check_r  <= '0;
      last_sent_r   <= '0;
      last_rx_r     <= '0;
      ack_pending_r <= 1'b0;
      retry_r       <= 8'd0;
      link_r        <= hls_pkg::LINK_CONNECTING;
      res_valid_r   <= 1'b0;
    end else begin
      if (take) begin
        now_ms_r      <= now_ms_nxt;
        last_check_r  <= last_check_nxt;
        last_sent_r   <= last_sent_nxt;
        last_rx_r     <= last_rx_nxt;
        ack_pending_r <= ack_pending_nxt;
        retry_r       <= retry_nxt;
        link_r        <= link_nxt;
        res_valid_r   <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // the held result always reflects the current link state
  a_status_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> (res_r.link_status == link_r))
    else $error("result link_status differs from link state");

  a_connect_clears_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && res_r.became_connected) |-> (retry_r == 8'd0 &&
      link_r == hls_pkg::LINK_CONNECTED))
    else $error("entering connected did not clear retries");

  a_payload_only_with_hb: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !res_r.send_heartbeat) |-> (res_r.heartbeat_payload == 8'd0))
    else $error("payload set without heartbeat");

  a_hb_ack_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r |-> !(res_r.send_heartbeat && res_r.send_ack))
    else $error("heartbeat and ack in one step");

  a_time_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.action == hls_pkg::ACT_TICK) |=> (now_ms_r == $past(now_inc)))
    else $error("tick did not advance the millisecond count");

endmodule

// File: design/heartbeat_link_supervisor.sv
// heartbeat_link_supervisor: top level of the link keepalive supervisor
// depends on hls_pkg, hls_if, hls_cfg_regs, hls_in_stage, hls_core
//
//   channel  | dir | handshake         | payload
//   in_ch    | in  | valid/ready       | action, frame_kind, tx_accepted
//   out_ch   | out | valid/ready       | link_status, send_heartbeat,
//            |     |                   | heartbeat_payload, send_ack, became_connected
//   cfg_*    | in  | cfg_we, no ready  | cfg_index, cfg_wdata
//
// one item per cycle while out_ch is ready; each result is registered after passing
// (input register, then one pass of compares and counters into the result register)
// synchronous active-low reset clears the valid flags and supervision state and loads the register defaults
// a stalled output holds its result; the input register still takes one more item
module heartbeat_link_supervisor (
  input  logic                              clk,
  input  logic                              rst_n,
  hls_in_if.sink                            in_ch,
  hls_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [hls_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hls_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  hls_pkg::cfg_t    cfg;
  hls_pkg::item_t   in_item;
  hls_pkg::item_t   item;
  logic             item_valid;
  logic             item_ready;
  logic             res_valid;
  hls_pkg::result_t res;

  assign in_item.action      = in_ch.action;
  assign in_item.frame_kind  = in_ch.frame_kind;
  assign in_item.tx_accepted = in_ch.tx_accepted;

  hls_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hls_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  hls_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (res_valid),
    .res_ready  (out_ch.ready),
    .res        (res)
  );

  assign out_ch.valid             = res_valid;
  assign out_ch.link_status       = res.link_status;
  assign out_ch.send_heartbeat    = res.send_heartbeat;
  assign out_ch.heartbeat_payload = res.heartbeat_payload;
  assign out_ch.send_ack          = res.send_ack;
  assign out_ch.became_connected  = res.became_connected;

endmodule
